@@ hdl/acc_tmc_pkg.sv @@
// Shared types, widths and constants of the accelerometer tilt and motion classifier.
`timescale 1ns / 1ps
`default_nettype none

package acc_tmc_pkg;

  // Field and datapath widths.
  localparam int unsigned SampleW  = 16;
  localparam int unsigned AbsW     = SampleW + 1;
  localparam int unsigned SqW      = 31;
  localparam int unsigned SumW     = 32;
  localparam int unsigned MagW     = 16;
  localparam int unsigned AngleW   = 9;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned ProdW    = 25;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // One square-root step per result bit.
  localparam int unsigned SqrtSteps = MagW;

  // angle = floor(|a| * 11 / 1000) as a multiply by 11 * ceil(2^29 / 1000) and a shift.
  localparam int unsigned AngleMulW  = 23;
  localparam int unsigned AngleProdW = AbsW + AngleMulW;
  localparam int unsigned AngleShift = 29;
  localparam logic [AngleMulW-1:0] AngleMul = 23'd5905581;

  // duty = floor(p / 90) as a multiply by ceil(2^31 / 90) and a shift.
  localparam int unsigned DutyMulW  = 25;
  localparam int unsigned DutyProdW = ProdW + DutyMulW;
  localparam int unsigned DutyShift = 31;
  localparam int unsigned DutyQW    = DutyProdW - DutyShift;
  localparam logic [DutyMulW-1:0] DutyMul = 25'd23860930;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgTiltLimitX   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTiltLimitY   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgStillSwing   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRestMag      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgAccelLimit   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPwmPeriod    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLedMinAngle  = 3'd6;

  // Configuration reset values.
  localparam logic [AngleW-1:0] RstTiltLimit   = 9'd15;
  localparam logic [LimitW-1:0] RstStillSwing  = 16'd500;
  localparam logic [LimitW-1:0] RstRestMag     = 16'd8000;
  localparam logic [LimitW-1:0] RstAccelLimit  = 16'd13000;
  localparam logic [LimitW-1:0] RstPwmPeriod   = 16'd4095;
  localparam logic [AngleW-1:0] RstLedMinAngle = 9'd5;

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [MagW-1:0]   magnitude;
    logic [AngleW-1:0] angle_x;
    logic [AngleW-1:0] angle_y;
    logic [LimitW-1:0] duty_x;
    logic [LimitW-1:0] duty_y;
    logic              tilted;
    logic              moving;
    logic              excessive;
  } out_item_t;

  typedef struct packed {
    logic [AngleW-1:0] tilt_limit_x;
    logic [AngleW-1:0] tilt_limit_y;
    logic [LimitW-1:0] still_swing;
    logic [LimitW-1:0] rest_magnitude;
    logic [LimitW-1:0] accel_limit;
    logic [LimitW-1:0] pwm_period_count;
    logic [AngleW-1:0] led_min_angle;
  } cfg_t;

  // Tilt results that ride along with the square root.
  typedef struct packed {
    logic [AngleW-1:0] angle_x;
    logic [AngleW-1:0] angle_y;
    logic [ProdW-1:0]  prod_x;
    logic [ProdW-1:0]  prod_y;
    logic              duty_en_x;
    logic              duty_en_y;
    logic              tilted;
  } tilt_tag_t;

endpackage

`default_nettype wire

@@ hdl/acc_tmc_sqsum.sv @@
// Two-stage sum of squares of the three absolute axis values.
`timescale 1ns / 1ps
`default_nettype none

module acc_tmc_sqsum (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic [acc_tmc_pkg::AbsW-1:0]    abs_x,
  input  wire logic [acc_tmc_pkg::AbsW-1:0]    abs_y,
  input  wire logic [acc_tmc_pkg::AbsW-1:0]    abs_z,
  output logic                                 out_valid,
  output logic [acc_tmc_pkg::SumW-1:0]         out_sum
);

  localparam int unsigned AbsW    = acc_tmc_pkg::AbsW;
  localparam int unsigned SqW     = acc_tmc_pkg::SqW;
  localparam int unsigned SumW    = acc_tmc_pkg::SumW;
  localparam int unsigned SqFullW = 2 * AbsW;

  logic [SqFullW-1:0] sqx_full, sqy_full, sqz_full;
  logic [SqW-1:0]     sqx_r, sqy_r, sqz_r;
  logic               sq_vld_r;
  logic [SumW-1:0]    sum_nxt, sum_r;
  logic               sum_vld_r;

  // Each square is at most 2^30, so 31 bits hold it.
  assign sqx_full = SqFullW'(abs_x) * SqFullW'(abs_x);
  assign sqy_full = SqFullW'(abs_y) * SqFullW'(abs_y);
  assign sqz_full = SqFullW'(abs_z) * SqFullW'(abs_z);

  // Three squares can reach 3 * 2^30, which still fits 32 bits.
  assign sum_nxt = SumW'(sqx_r) + SumW'(sqy_r) + SumW'(sqz_r);

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
    end else begin
      sq_vld_r  <= in_valid;
      sum_vld_r <= sq_vld_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    sqx_r <= sqx_full[SqW-1:0];
    sqy_r <= sqy_full[SqW-1:0];
    sqz_r <= sqz_full[SqW-1:0];
    sum_r <= sum_nxt;
  end

  assign out_valid = sum_vld_r;
  assign out_sum   = sum_r;

endmodule

`default_nettype wire

@@ hdl/acc_tmc_tilt.sv @@
// Two-stage tilt angle, duty product and tilt flag computation for X and Y.
`timescale 1ns / 1ps
`default_nettype none

module acc_tmc_tilt (
  input  wire logic                         clk,
  input  wire acc_tmc_pkg::cfg_t            cfg,
  input  wire logic [acc_tmc_pkg::AbsW-1:0] abs_x,
  input  wire logic [acc_tmc_pkg::AbsW-1:0] abs_y,
  output acc_tmc_pkg::tilt_tag_t            out_tag
);

  localparam int unsigned AngleW     = acc_tmc_pkg::AngleW;
  localparam int unsigned ProdW      = acc_tmc_pkg::ProdW;
  localparam int unsigned AngleProdW = acc_tmc_pkg::AngleProdW;
  localparam int unsigned AngleShift = acc_tmc_pkg::AngleShift;

  logic [AngleProdW-1:0] angx_prod, angy_prod;
  logic [AngleW-1:0]     angx_r, angy_r;
  acc_tmc_pkg::tilt_tag_t tag_nxt, tag_r;

  // Stage one: angle by reciprocal multiplication; exact for every 17-bit magnitude.
  assign angx_prod = AngleProdW'(abs_x) * AngleProdW'(acc_tmc_pkg::AngleMul);
  assign angy_prod = AngleProdW'(abs_y) * AngleProdW'(acc_tmc_pkg::AngleMul);

  // Stage two: duty products, duty enables and the tilt flag.
  always_comb begin
    tag_nxt.angle_x   = angx_r;
    tag_nxt.angle_y   = angy_r;
    tag_nxt.prod_x    = ProdW'(angx_r) * ProdW'(cfg.pwm_period_count);
    tag_nxt.prod_y    = ProdW'(angy_r) * ProdW'(cfg.pwm_period_count);
    tag_nxt.duty_en_x = angx_r > cfg.led_min_angle;
    tag_nxt.duty_en_y = angy_r > cfg.led_min_angle;
    tag_nxt.tilted    = (angx_r > cfg.tilt_limit_x) || (angy_r > cfg.tilt_limit_y);
  end

  always_ff @(posedge clk) begin
    angx_r <= angx_prod[AngleShift +: AngleW];
    angy_r <= angy_prod[AngleShift +: AngleW];
    tag_r  <= tag_nxt;
  end

  assign out_tag = tag_r;

endmodule

`default_nettype wire

@@ hdl/acc_tmc_sqrt.sv @@
// Pipelined integer square root, one result bit per stage, with a side tag carried along.
`timescale 1ns / 1ps
`default_nettype none

module acc_tmc_sqrt (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [acc_tmc_pkg::SumW-1:0] in_rad,
  input  wire acc_tmc_pkg::tilt_tag_t       in_tag,
  output logic                              out_valid,
  output logic [acc_tmc_pkg::MagW-1:0]      out_root,
  output acc_tmc_pkg::tilt_tag_t            out_tag
);

  localparam int unsigned Steps  = acc_tmc_pkg::SqrtSteps;
  localparam int unsigned SumW   = acc_tmc_pkg::SumW;
  localparam int unsigned MagW   = acc_tmc_pkg::MagW;
  localparam int unsigned RemW   = MagW + 2;
  localparam int unsigned TrialW = RemW + 2;

  logic                   vld_r  [Steps];
  logic [SumW-1:0]        rad_r  [Steps];
  logic [RemW-1:0]        rem_r  [Steps];
  logic [MagW-1:0]        root_r [Steps];
  acc_tmc_pkg::tilt_tag_t tag_r  [Steps];

  genvar k;
  generate
    for (k = 0; k < Steps; k++) begin : g_step
      logic                   cur_vld;
      logic [SumW-1:0]        cur_rad;
      logic [RemW-1:0]        cur_rem;
      logic [MagW-1:0]        cur_root;
      acc_tmc_pkg::tilt_tag_t cur_tag;
      logic [TrialW-1:0]      tval, trial;
      logic                   fit;

      // The first step starts from the radicand with an empty root and remainder.
      if (k == 0) begin : g_first
        assign cur_vld  = in_valid;
        assign cur_rad  = in_rad;
        assign cur_rem  = '0;
        assign cur_root = '0;
        assign cur_tag  = in_tag;
      end else begin : g_next
        assign cur_vld  = vld_r[k-1];
        assign cur_rad  = rad_r[k-1];
        assign cur_rem  = rem_r[k-1];
        assign cur_root = root_r[k-1];
        assign cur_tag  = tag_r[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign tval  = {cur_rem, cur_rad[SumW-1 -: 2]};
      assign trial = TrialW'({cur_root, 2'b01});
      assign fit   = tval >= trial;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= cur_vld;
        end
      end

      // The remainder stays below 2 * root + 1, so RemW bits hold it.
      always_ff @(posedge clk) begin
        rad_r[k]  <= {cur_rad[SumW-3:0], 2'b00};
        rem_r[k]  <= fit ? RemW'(tval - trial) : RemW'(tval);
        root_r[k] <= {cur_root[MagW-2:0], fit};
        tag_r[k]  <= cur_tag;
      end
    end
  endgenerate

  assign out_valid = vld_r[Steps-1];
  assign out_root  = root_r[Steps-1];
  assign out_tag   = tag_r[Steps-1];

endmodule

`default_nettype wire

@@ hdl/accel_tilt_motion_classifier.sv @@
// Top level: accelerometer tilt and motion classifier with configuration registers.
// Pipeline: a result appears after its item passes the input register, the two
// sum-of-squares stages, the 16 square-root stages and the output register.
// Throughput: one item per cycle; busy stays low, and the square-root pipeline sets the depth.
// Reset: synchronous active-low reset clears all valid bits and loads the register defaults.
// Each result is on out_item for one cycle with out_valid high; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module accel_tilt_motion_classifier (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire acc_tmc_pkg::in_item_t             in_item,
  output logic                                   out_valid,
  output acc_tmc_pkg::out_item_t                 out_item,
  input  wire logic                              cfg_we,
  input  wire logic [acc_tmc_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [acc_tmc_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int unsigned SampleW   = acc_tmc_pkg::SampleW;
  localparam int unsigned AbsW      = acc_tmc_pkg::AbsW;
  localparam int unsigned SumW      = acc_tmc_pkg::SumW;
  localparam int unsigned MagW      = acc_tmc_pkg::MagW;
  localparam int unsigned AngleW    = acc_tmc_pkg::AngleW;
  localparam int unsigned LimitW    = acc_tmc_pkg::LimitW;
  localparam int unsigned DutyProdW = acc_tmc_pkg::DutyProdW;
  localparam int unsigned DutyShift = acc_tmc_pkg::DutyShift;
  localparam int unsigned DutyQW    = acc_tmc_pkg::DutyQW;
  localparam int unsigned WideW     = MagW + 1;

  acc_tmc_pkg::cfg_t      cfg_r;
  logic                   accept;
  logic                   abs_vld_r;
  logic [AbsW-1:0]        absx_nxt, absy_nxt, absz_nxt;
  logic [AbsW-1:0]        absx_r, absy_r, absz_r;
  logic                   sum_vld;
  logic [SumW-1:0]        sum;
  acc_tmc_pkg::tilt_tag_t tilt_tag;
  logic                   root_vld;
  logic [MagW-1:0]        root;
  acc_tmc_pkg::tilt_tag_t root_tag;
  logic [DutyProdW-1:0]   dutyx_prod, dutyy_prod;
  logic [DutyQW-1:0]      dutyx_q, dutyy_q;
  logic [WideW-1:0]       mag_w, rest_w, rest_hi, mag_hi;
  acc_tmc_pkg::out_item_t out_nxt, out_r;
  logic                   out_vld_r;

  // The pipeline never stalls, so an item is taken on every start.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tilt_limit_x     <= acc_tmc_pkg::RstTiltLimit;
      cfg_r.tilt_limit_y     <= acc_tmc_pkg::RstTiltLimit;
      cfg_r.still_swing      <= acc_tmc_pkg::RstStillSwing;
      cfg_r.rest_magnitude   <= acc_tmc_pkg::RstRestMag;
      cfg_r.accel_limit      <= acc_tmc_pkg::RstAccelLimit;
      cfg_r.pwm_period_count <= acc_tmc_pkg::RstPwmPeriod;
      cfg_r.led_min_angle    <= acc_tmc_pkg::RstLedMinAngle;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acc_tmc_pkg::CfgTiltLimitX:  cfg_r.tilt_limit_x     <= cfg_wdata[AngleW-1:0];
        acc_tmc_pkg::CfgTiltLimitY:  cfg_r.tilt_limit_y     <= cfg_wdata[AngleW-1:0];
        acc_tmc_pkg::CfgStillSwing:  cfg_r.still_swing      <= cfg_wdata[LimitW-1:0];
        acc_tmc_pkg::CfgRestMag:     cfg_r.rest_magnitude   <= cfg_wdata[LimitW-1:0];
        acc_tmc_pkg::CfgAccelLimit:  cfg_r.accel_limit      <= cfg_wdata[LimitW-1:0];
        acc_tmc_pkg::CfgPwmPeriod:   cfg_r.pwm_period_count <= cfg_wdata[LimitW-1:0];
        acc_tmc_pkg::CfgLedMinAngle: cfg_r.led_min_angle    <= cfg_wdata[AngleW-1:0];
        default: ;
      endcase
    end
  end

  // Input stage: absolute values of the sign-extended samples; the most negative
  // sample becomes 32768.
  assign absx_nxt = in_item.accel_x[SampleW-1]
                  ? AbsW'(0) - {in_item.accel_x[SampleW-1], in_item.accel_x}
                  : {1'b0, in_item.accel_x};
  assign absy_nxt = in_item.accel_y[SampleW-1]
                  ? AbsW'(0) - {in_item.accel_y[SampleW-1], in_item.accel_y}
                  : {1'b0, in_item.accel_y};
  assign absz_nxt = in_item.accel_z[SampleW-1]
                  ? AbsW'(0) - {in_item.accel_z[SampleW-1], in_item.accel_z}
                  : {1'b0, in_item.accel_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      abs_vld_r <= 1'b0;
    end else begin
      abs_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    absx_r <= absx_nxt;
    absy_r <= absy_nxt;
    absz_r <= absz_nxt;
  end

  // Sum of squares and tilt path run side by side, two stages each.
  acc_tmc_sqsum u_sqsum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (abs_vld_r),
    .abs_x     (absx_r),
    .abs_y     (absy_r),
    .abs_z     (absz_r),
    .out_valid (sum_vld),
    .out_sum   (sum)
  );

  acc_tmc_tilt u_tilt (
    .clk     (clk),
    .cfg     (cfg_r),
    .abs_x   (absx_r),
    .abs_y   (absy_r),
    .out_tag (tilt_tag)
  );

  acc_tmc_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sum_vld),
    .in_rad    (sum),
    .in_tag    (tilt_tag),
    .out_valid (root_vld),
    .out_root  (root),
    .out_tag   (root_tag)
  );

  // Duty counts: divide by 90 by a reciprocal multiply; saturate, or zero when not enabled.
  assign dutyx_prod = DutyProdW'(root_tag.prod_x) * DutyProdW'(acc_tmc_pkg::DutyMul);
  assign dutyy_prod = DutyProdW'(root_tag.prod_y) * DutyProdW'(acc_tmc_pkg::DutyMul);
  assign dutyx_q    = dutyx_prod[DutyShift +: DutyQW];
  assign dutyy_q    = dutyy_prod[DutyShift +: DutyQW];

  // Motion test as a true absolute difference, done with two widened compares.
  assign mag_w   = WideW'(root);
  assign rest_w  = WideW'(cfg_r.rest_magnitude);
  assign rest_hi = rest_w + WideW'(cfg_r.still_swing);
  assign mag_hi  = mag_w + WideW'(cfg_r.still_swing);

  always_comb begin
    out_nxt.magnitude = root;
    out_nxt.angle_x   = root_tag.angle_x;
    out_nxt.angle_y   = root_tag.angle_y;
    if (!root_tag.duty_en_x) begin
      out_nxt.duty_x = '0;
    end else if (dutyx_q[DutyQW-1:LimitW] != '0) begin
      out_nxt.duty_x = '1;
    end else begin
      out_nxt.duty_x = dutyx_q[LimitW-1:0];
    end
    if (!root_tag.duty_en_y) begin
      out_nxt.duty_y = '0;
    end else if (dutyy_q[DutyQW-1:LimitW] != '0) begin
      out_nxt.duty_y = '1;
    end else begin
      out_nxt.duty_y = dutyy_q[LimitW-1:0];
    end
    out_nxt.tilted    = root_tag.tilted;
    out_nxt.moving    = (mag_w > rest_hi) || (rest_w > mag_hi);
    out_nxt.excessive = root > cfg_r.accel_limit;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= root_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire
